>>> hw/rtl/ded_pkg.sv
// Shared types and constants for the dual elevator dispatch unit.
// No dependencies; used by ded_ctrl, ded_dpath and the top level.
package ded_pkg;

  localparam int SLOTS   = 128;
  localparam int FLOORS  = 16;
  localparam int FLOOR_W = 5;
  localparam int LOAD_W  = 6;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SCORE_W = $clog2(3 * SLOTS + 1) + 1;
  localparam int ADDR_W  = 4;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 80;

  localparam logic [FLOOR_W:0] FLOOR_MAX = (FLOOR_W + 1)'(FLOORS);

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_CAR1     = 2'd1;
  localparam logic [1:0] REG_CAR2     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ_SCAN,
    ST_LV_RD,
    ST_LV_WR,
    ST_BD_RD,
    ST_BD_WR,
    ST_MOVE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic idx_clr;
    logic idx_inc;
    logic store;
    logic leave_wr;
    logic board_wr;
    logic move;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic req_skip;
    logic slot_free;
    logic idx_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic              used;
    logic [FLOOR_W-1:0] from_f;
    logic [FLOOR_W-1:0] to_f;
    logic              in1;
    logic              in2;
  } slot_t;

  function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] v);
    logic [FLOOR_W-1:0] r;
    r = v;
    if (v == '0) r = FLOOR_W'(1);
    else if ({1'b0, v} > FLOOR_MAX) r = FLOOR_MAX[FLOOR_W-1:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/ded_ctrl.sv
// Sequencer for the dispatch unit: steps requests and ticks through table passes.
// Depends on ded_pkg; drives ded_dpath through cmd_t, reads status_t.
module ded_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ded_pkg::status_t sts,
  output ded_pkg::cmd_t    cmd
);

  ded_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ded_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ded_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_nxt     = ded_pkg::ST_REQ_SCAN;
        end
      end
      ded_pkg::ST_REQ_SCAN: begin
        if (sts.is_tick) begin
          state_nxt = ded_pkg::ST_LV_RD;
        end else if (sts.req_skip) begin
          state_nxt = ded_pkg::ST_EMIT;
        end else if (sts.slot_free) begin
          cmd.store = 1'b1;
          state_nxt = ded_pkg::ST_EMIT;
        end else if (sts.idx_last) begin
          state_nxt = ded_pkg::ST_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ded_pkg::ST_LV_RD: state_nxt = ded_pkg::ST_LV_WR;
      ded_pkg::ST_LV_WR: begin
        cmd.leave_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ded_pkg::ST_BD_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ded_pkg::ST_LV_RD;
        end
      end
      ded_pkg::ST_BD_RD: state_nxt = ded_pkg::ST_BD_WR;
      ded_pkg::ST_BD_WR: begin
        cmd.board_wr = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ded_pkg::ST_MOVE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ded_pkg::ST_BD_RD;
        end
      end
      ded_pkg::ST_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = ded_pkg::ST_EMIT;
      end
      ded_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ded_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ded_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/ded_dpath.sv
// Datapath: passenger table, car state, counters, config registers, result register.
// Depends on ded_pkg; commanded by ded_ctrl.
module ded_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ded_pkg::cmd_t               cmd,
  output ded_pkg::status_t            sts,
  input  logic                        in_tuser,
  input  logic [ded_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ded_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ded_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata
);

  localparam int FW = ded_pkg::FLOOR_W;
  localparam int LW = ded_pkg::LOAD_W;
  localparam int SW = ded_pkg::SCORE_W;

  // table: valid bits in flops, payload in memory
  logic [ded_pkg::SLOTS-1:0] valid_r;
  ded_pkg::slot_t            mem [ded_pkg::SLOTS];
  ded_pkg::slot_t            rd_q;
  logic                      mem_we;
  ded_pkg::slot_t            mem_wd;

  logic [ded_pkg::IDX_W-1:0] idx_r;
  logic [ded_pkg::CNT_W-1:0] pend_r;
  logic [LW-1:0]             load1_r, load2_r, cap_r;
  logic [FW-1:0]             start1_r, start2_r, pos1_r, pos2_r, f1_r, f2_r;
  logic [FW-1:0]             from_r, to_r;
  logic                      tick_r, acc_r;
  logic [31:0]               tick_cnt_r;
  logic [SW-1:0]             up1_r, dn1_r, up2_r, dn2_r;
  logic                      out_valid_r;
  logic [ded_pkg::OUT_W-1:0] out_data_r;

  logic cfg_wr;
  logic v_cur, leave, b1, b2, r1, r2;
  logic rise1, rise2;
  logic [FW-1:0] nxt1, nxt2;
  logic [SW-1:0] a_up1, a_dn1, a_up2, a_dn2;

  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign v_cur  = valid_r[idx_r];

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[3:2])
      ded_pkg::REG_CAPACITY: cfg_prdata = 32'(cap_r);
      ded_pkg::REG_CAR1:     cfg_prdata = 32'(start1_r);
      ded_pkg::REG_CAR2:     cfg_prdata = 32'(start2_r);
      default:               cfg_prdata = '0;
    endcase
  end

  assign sts.is_tick   = tick_r;
  assign sts.req_skip  = (from_r == to_r);
  assign sts.slot_free = ~v_cur;
  assign sts.idx_last  = (idx_r == ded_pkg::IDX_W'(ded_pkg::SLOTS - 1));
  assign sts.out_free  = ~out_valid_r | out_tready;

  // per-slot decisions
  always_comb begin
    leave = v_cur & ((rd_q.in1 & (rd_q.to_f == f1_r)) | (rd_q.in2 & (rd_q.to_f == f2_r)));
    b1 = v_cur & ~rd_q.in1 & ~rd_q.in2 & (rd_q.from_f == f1_r) & (load1_r < cap_r);
    b2 = v_cur & ~rd_q.in1 & ~rd_q.in2 & ~b1 & (rd_q.from_f == f2_r) & (load2_r < cap_r);
    r1 = rd_q.in1 | b1;
    r2 = rd_q.in2 | b2;
    a_up1 = '0; a_dn1 = '0; a_up2 = '0; a_dn2 = '0;
    if (v_cur) begin
      if (r1) begin
        if (rd_q.to_f > f1_r) a_up1 = SW'(3);
        if (rd_q.to_f < f1_r) a_dn1 = SW'(3);
      end else begin
        if (rd_q.from_f > f1_r) a_up1 = SW'(1);
        if (rd_q.from_f < f1_r) a_dn1 = SW'(1);
      end
      if (r2) begin
        if (rd_q.to_f > f2_r) a_up2 = SW'(3);
        if (rd_q.to_f < f2_r) a_dn2 = SW'(3);
      end else begin
        if (rd_q.from_f > f2_r) a_up2 = SW'(1);
        if (rd_q.from_f < f2_r) a_dn2 = SW'(1);
      end
    end
    mem_we      = cmd.store | (cmd.board_wr & (b1 | b2));
    mem_wd.used = 1'b1;
    if (cmd.store) begin
      mem_wd.from_f = from_r;
      mem_wd.to_f   = to_r;
      mem_wd.in1    = 1'b0;
      mem_wd.in2    = 1'b0;
    end else begin
      mem_wd.from_f = rd_q.from_f;
      mem_wd.to_f   = rd_q.to_f;
      mem_wd.in1    = r1;
      mem_wd.in2    = r2;
    end
  end

  always_comb begin
    rise1 = ({up1_r, 1'b0} >= {1'b0, dn1_r});
    rise2 = ({1'b0, up2_r} >= {dn2_r, 1'b0});
    if (rise1) nxt1 = ({1'b0, f1_r} >= ded_pkg::FLOOR_MAX) ? f1_r : f1_r + FW'(1);
    else       nxt1 = (f1_r <= FW'(1)) ? FW'(1) : f1_r - FW'(1);
    if (rise2) nxt2 = ({1'b0, f2_r} >= ded_pkg::FLOOR_MAX) ? f2_r : f2_r + FW'(1);
    else       nxt2 = (f2_r <= FW'(1)) ? FW'(1) : f2_r - FW'(1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_r] <= mem_wd;
    rd_q <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      tick_r <= in_tuser;
      from_r <= ded_pkg::clamp_floor(in_tdata[FW-1:0]);
      to_r   <= ded_pkg::clamp_floor(in_tdata[2*FW-1:FW]);
      f1_r   <= pos1_r;
      f2_r   <= pos2_r;
      up1_r  <= '0;
      dn1_r  <= '0;
      up2_r  <= '0;
      dn2_r  <= '0;
    end else if (cmd.board_wr) begin
      up1_r <= up1_r + a_up1;
      dn1_r <= dn1_r + a_dn1;
      up2_r <= up2_r + a_up2;
      dn2_r <= dn2_r + a_dn2;
    end
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + ded_pkg::IDX_W'(1);
    if (cmd.emit) begin
      out_data_r <= {7'd0, tick_cnt_r, pos2_r, pos1_r, 8'(pend_r), load2_r, load1_r,
                     f2_r, f1_r, acc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      pend_r      <= '0;
      load1_r     <= '0;
      load2_r     <= '0;
      cap_r       <= LW'(4);
      start1_r    <= FW'(1);
      start2_r    <= FW'(1);
      pos1_r      <= FW'(1);
      pos2_r      <= FW'(1);
      tick_cnt_r  <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_item) acc_r <= 1'b0;
      if (cmd.store) begin
        valid_r[idx_r] <= 1'b1;
        pend_r         <= pend_r + ded_pkg::CNT_W'(1);
        acc_r          <= 1'b1;
      end
      if (cmd.leave_wr && leave) begin
        valid_r[idx_r] <= 1'b0;
        pend_r         <= pend_r - ded_pkg::CNT_W'(1);
        if (rd_q.in1) load1_r <= load1_r - LW'(1);
        if (rd_q.in2) load2_r <= load2_r - LW'(1);
      end
      if (cmd.board_wr) begin
        if (b1) load1_r <= load1_r + LW'(1);
        if (b2) load2_r <= load2_r + LW'(1);
      end
      if (cmd.move) begin
        pos1_r     <= nxt1;
        pos2_r     <= nxt2;
        tick_cnt_r <= tick_cnt_r + 32'd1;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          ded_pkg::REG_CAPACITY: cap_r <= cfg_pwdata[LW-1:0];
          ded_pkg::REG_CAR1: begin
            start1_r <= cfg_pwdata[FW-1:0];
            pos1_r   <= ded_pkg::clamp_floor(cfg_pwdata[FW-1:0]);
          end
          ded_pkg::REG_CAR2: begin
            start2_r <= cfg_pwdata[FW-1:0];
            pos2_r   <= ded_pkg::clamp_floor(cfg_pwdata[FW-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/dual_elevator_dispatch_unit.sv
// Top level of the dual elevator dispatch unit: sequencer plus datapath.
// Depends on ded_pkg, ded_ctrl and ded_dpath.
//
// One transaction is taken at a time. A request scans the table one slot per cycle for
// the first free slot. A tick makes two passes over the table (riders leave; boarding
// plus scoring), each slot taking a read state and a write state on the single-port
// table memory, then moves both cars. The result sits in an output register, and the
// next transaction is accepted while it waits. The table's valid bits clear at reset,
// so no clearing pass is needed. Configuration is to be written by the user through
// the APB-style port only while idle; the block itself does not enforce this.
module dual_elevator_dispatch_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,  // [0] req_type
  input  logic [ded_pkg::IN_W-1:0]    in_tdata,  // [4:0] start_floor, [9:5] target_floor
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] accepted, [5:1] car1_floor, [10:6] car2_floor, [16:11] car1_load,
  // [22:17] car2_load, [30:23] pending_count, [35:31] car1_next_floor,
  // [40:36] car2_next_floor, [72:41] tick_number
  output logic [ded_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ded_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  ded_pkg::cmd_t    cmd;
  ded_pkg::status_t sts;

  assign cfg_pready = 1'b1;

  ded_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ded_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata)
  );

endmodule
